[src/union_find_edge_selector_assert.svh]
// Assertion macros used by the checker file.
// Both expect signals named clk and arst_n in the scope where they are used.
`ifndef UNION_FIND_EDGE_SELECTOR_ASSERT_SVH
`define UNION_FIND_EDGE_SELECTOR_ASSERT_SVH

// Same-cycle implication, off while reset is asserted
`define UFES_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, off while reset is asserted
`define UFES_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/ufes_pkg.sv]
`timescale 1ns / 1ps

package ufes_pkg;

	// Field widths
	localparam int NODE_W   = 10;
	localparam int COUNT_W  = 11;
	localparam int WEIGHT_W = 32;
	localparam int SUM_W    = 48;
	localparam int RANK_W   = 4;

	// Item function codes
	localparam logic FUNC_CLEAR = 1'b0;
	localparam logic FUNC_EDGE  = 1'b1;

	// Register indexes (word address bit above the byte offset)
	localparam logic REG_NODE_COUNT = 1'b0;
	localparam logic [COUNT_W-1:0] NODE_COUNT_RST = 11'd1024;

	// Rank and sum limits
	localparam logic [RANK_W-1:0] RANK_INIT = 4'd1;
	localparam logic [RANK_W-1:0] RANK_MAX  = 4'd15;
	localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_FIND,
		ST_COMP,
		ST_LINK,
		ST_RANK,
		ST_CLEAR,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic                       func;
		logic [NODE_W-1:0]          src_node;
		logic [NODE_W-1:0]          dst_node;
		logic signed [WEIGHT_W-1:0] edge_weight;
	} item_t;

	typedef struct packed {
		logic                    edge_taken;
		logic                    closed_cycle;
		logic signed [SUM_W-1:0] total_weight;
	} res_t;

	// New rank of the surviving root: max(lower + 1, upper), saturating
	function automatic logic [RANK_W-1:0] rank_after(input logic [RANK_W-1:0] lower,
		input logic [RANK_W-1:0] upper);
		logic [RANK_W:0] bumped;
		logic [RANK_W:0] r;
		bumped = {1'b0, lower} + (RANK_W+1)'(1);
		r = (bumped > {1'b0, upper}) ? bumped : {1'b0, upper};
		return (r > {1'b0, RANK_MAX}) ? RANK_MAX : r[RANK_W-1:0];
	endfunction

	// Saturating add of a weight to the running total
	function automatic logic signed [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] sum,
		input logic signed [WEIGHT_W-1:0] w);
		logic signed [SUM_W:0] s;
		s = {sum[SUM_W-1], sum} + {{(SUM_W+1-WEIGHT_W){w[WEIGHT_W-1]}}, w};
		if (s[SUM_W] != s[SUM_W-1]) begin
			return s[SUM_W] ? SUM_MIN : SUM_MAX;
		end
		return s[SUM_W-1:0];
	endfunction

endpackage

[src/ufes_ram.sv]
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port with registered data
module ufes_ram #(
	parameter int WIDTH = 14,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

[src/ufes_ctrl.sv]
`timescale 1ns / 1ps

// Sequencer: root walks, path compression and linking over the forest memory
module ufes_ctrl import ufes_pkg::*; #(
	parameter int MAX_NODES = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [COUNT_W-1:0] node_count,
	input  logic               req_valid,
	input  item_t              req_item,
	output logic               req_stall,
	output logic               res_valid,
	input  logic               res_ready,
	output res_t               res
);

	localparam int NW = $clog2(MAX_NODES);
	localparam int EW = NW + RANK_W;
	localparam logic [NW-1:0] LAST_NODE = NW'(MAX_NODES - 1);

	state_t state_q, state_d;

	logic [NW-1:0]              sweep_q;
	logic                       side_q;
	logic [NW-1:0]              cur_q;
	logic [NW-1:0]              u_q;
	logic [NW-1:0]              v_q;
	logic [NW-1:0]              root0_q;
	logic [NW-1:0]              root1_q;
	logic [RANK_W-1:0]          rank0_q;
	logic [RANK_W-1:0]          rank1_q;
	logic signed [WEIGHT_W-1:0] weight_q;
	logic                       taken_q;
	logic                       closed_q;
	logic                       cycle_used_q;
	logic signed [SUM_W-1:0]    sum_q;

	logic          wr_en;
	logic [NW-1:0] wr_addr;
	logic [EW-1:0] wr_data;
	logic [NW-1:0] rd_addr;
	logic [EW-1:0] rd_data;

	logic              req_acc;
	logic              in_range;
	logic [NW-1:0]     src_idx;
	logic [NW-1:0]     rd_par;
	logic [RANK_W-1:0] rd_rank;
	logic [NW-1:0]     start_node;
	logic [NW-1:0]     root_cur;
	logic              is_root;
	logic              at_root;
	logic              at_start;
	logic              same_root;
	logic              link_lo;
	logic              sweep_last;

	ufes_ram #(
		.WIDTH(EW),
		.DEPTH(MAX_NODES)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// Decode of the memory word and walk status
	assign rd_par     = rd_data[EW-1:RANK_W];
	assign rd_rank    = rd_data[RANK_W-1:0];
	assign start_node = side_q ? v_q : u_q;
	assign root_cur   = side_q ? root1_q : root0_q;
	assign is_root    = (rd_par == cur_q);
	assign at_root    = (cur_q == root_cur);
	assign at_start   = (cur_q == start_node);
	assign same_root  = (root0_q == root1_q);
	assign link_lo    = (rank0_q < rank1_q);
	assign sweep_last = (sweep_q == LAST_NODE);
	assign src_idx    = NW'(req_item.src_node);

	// Endpoints must lie below both the node count and the forest size
	assign in_range = ({1'b0, req_item.src_node} < node_count) &&
		({1'b0, req_item.dst_node} < node_count) &&
		(32'(req_item.src_node) < MAX_NODES) &&
		(32'(req_item.dst_node) < MAX_NODES);

	assign req_acc = req_valid && !req_stall;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: begin
				if (sweep_last) state_d = ST_IDLE;
			end
			ST_CLEAR: begin
				if (sweep_last) state_d = ST_DONE;
			end
			ST_IDLE: begin
				if (req_acc) begin
					if (req_item.func == FUNC_CLEAR) state_d = ST_CLEAR;
					else if (in_range) state_d = ST_FIND;
					else state_d = ST_DONE;
				end
			end
			ST_FIND: begin
				if (is_root) begin
					if (!at_start) state_d = ST_COMP;
					else if (side_q) state_d = ST_LINK;
				end
			end
			ST_COMP: begin
				if (at_root) state_d = side_q ? ST_LINK : ST_FIND;
			end
			ST_LINK: begin
				state_d = same_root ? ST_DONE : ST_RANK;
			end
			ST_RANK: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (res_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_INIT;
		endcase
	end

	// Memory port and handshake outputs
	always_comb begin
		req_stall = 1'b1;
		res_valid = 1'b0;
		wr_en     = 1'b0;
		wr_addr   = cur_q;
		wr_data   = {root_cur, rd_rank};
		rd_addr   = cur_q;
		case (state_q)
			ST_INIT, ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = sweep_q;
				wr_data = {sweep_q, RANK_INIT};
			end
			ST_IDLE: begin
				req_stall = 1'b0;
				rd_addr   = src_idx;
			end
			ST_FIND: begin
				if (!is_root) rd_addr = rd_par;
				else if (!at_start) rd_addr = start_node;
				else rd_addr = v_q;
			end
			ST_COMP: begin
				// point the visited node at its root and step on
				if (at_root) begin
					rd_addr = v_q;
				end else begin
					wr_en   = 1'b1;
					rd_addr = rd_par;
				end
			end
			ST_LINK: begin
				wr_en   = !same_root;
				wr_addr = link_lo ? root0_q : root1_q;
				wr_data = link_lo ? {root1_q, rank0_q} : {root0_q, rank1_q};
			end
			ST_RANK: begin
				wr_en   = 1'b1;
				wr_addr = link_lo ? root1_q : root0_q;
				wr_data = link_lo ? {root1_q, rank_after(rank0_q, rank1_q)}
					: {root0_q, rank_after(rank1_q, rank0_q)};
			end
			ST_DONE: begin
				res_valid = 1'b1;
			end
			default: begin
				req_stall = 1'b1;
			end
		endcase
	end

	assign res.edge_taken   = taken_q;
	assign res.closed_cycle = closed_q;
	assign res.total_weight = sum_q;

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_INIT;
			sweep_q      <= '0;
			cycle_used_q <= 1'b0;
			sum_q        <= '0;
			taken_q      <= 1'b0;
			closed_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_INIT, ST_CLEAR: begin
					sweep_q <= sweep_last ? '0 : sweep_q + NW'(1);
				end
				ST_IDLE: begin
					if (req_acc) begin
						taken_q  <= 1'b0;
						closed_q <= 1'b0;
						if (req_item.func == FUNC_CLEAR) begin
							cycle_used_q <= 1'b0;
							sum_q        <= '0;
						end
					end
				end
				ST_LINK: begin
					if (!same_root) begin
						taken_q <= 1'b1;
						sum_q   <= sat_add(sum_q, weight_q);
					end else if (!cycle_used_q) begin
						taken_q      <= 1'b1;
						closed_q     <= 1'b1;
						cycle_used_q <= 1'b1;
						sum_q        <= sat_add(sum_q, weight_q);
					end
				end
				default: begin
					sweep_q <= sweep_q;
				end
			endcase
		end
	end

	// Walk registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (req_acc) begin
					u_q      <= src_idx;
					v_q      <= NW'(req_item.dst_node);
					cur_q    <= src_idx;
					side_q   <= 1'b0;
					weight_q <= req_item.edge_weight;
				end
			end
			ST_FIND: begin
				if (is_root) begin
					if (side_q) begin
						root1_q <= cur_q;
						rank1_q <= rd_rank;
					end else begin
						root0_q <= cur_q;
						rank0_q <= rd_rank;
					end
					if (!at_start) begin
						cur_q <= start_node;
					end else if (!side_q) begin
						side_q <= 1'b1;
						cur_q  <= v_q;
					end
				end else begin
					cur_q <= rd_par;
				end
			end
			ST_COMP: begin
				if (at_root) begin
					side_q <= 1'b1;
					cur_q  <= v_q;
				end else begin
					cur_q <= rd_par;
				end
			end
			default: begin
				cur_q <= cur_q;
			end
		endcase
	end

endmodule

[src/union_find_edge_selector.sv]
`timescale 1ns / 1ps
// Edge item: each endpoint in turn is walked to its root, then any path behind it is compressed onto
// that root (walk, then compress, one memory access a cycle); two different roots are then linked and
// the surviving root's rank is updated, while one shared root gives no link. Refused out-of-range edge: no walk.
// Clear item: rewrites every forest entry (one entry per cycle).
// One item in flight; a new item is taken while the previous result waits in the output stage.
// Reset: async, active low; then a pass over all MAX_NODES entries initializes the forest, no items taken.
module union_find_edge_selector import ufes_pkg::*; #(
	parameter int MAX_NODES = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// configuration port
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [2:0]                 paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	// item channel
	input  logic                       req_valid,
	output logic                       req_stall,
	input  logic                       func,
	input  logic [NODE_W-1:0]          src_node,
	input  logic [NODE_W-1:0]          dst_node,
	input  logic signed [WEIGHT_W-1:0] edge_weight,
	// result channel
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output logic                       edge_taken,
	output logic                       closed_cycle,
	output logic signed [SUM_W-1:0]    total_weight
);

	logic [COUNT_W-1:0] node_count_q;
	logic               cfg_wr;
	item_t              req_item;
	res_t               res;
	logic               res_valid;
	logic               res_ready;
	logic               rsp_valid_q;
	res_t               rsp_q;

	// Register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == REG_NODE_COUNT) ? 32'(node_count_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NODE_COUNT_RST;
		end else if (cfg_wr && (paddr[2] == REG_NODE_COUNT)) begin
			node_count_q <= pwdata[COUNT_W-1:0];
		end
	end

	assign req_item.func        = func;
	assign req_item.src_node    = src_node;
	assign req_item.dst_node    = dst_node;
	assign req_item.edge_weight = edge_weight;

	ufes_ctrl #(
		.MAX_NODES(MAX_NODES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.node_count(node_count_q),
		.req_valid (req_valid),
		.req_item  (req_item),
		.req_stall (req_stall),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// Output stage
	assign res_ready = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_ready) begin
			rsp_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign edge_taken   = rsp_q.edge_taken;
	assign closed_cycle = rsp_q.closed_cycle;
	assign total_weight = rsp_q.total_weight;

endmodule

[src/ufes_chk.sv]
`timescale 1ns / 1ps
`include "union_find_edge_selector_assert.svh"

// Port-level checks on the edge selector
module ufes_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               req_stall,
	input logic               rsp_valid,
	input logic               rsp_stall,
	input logic               edge_taken,
	input logic               closed_cycle,
	input logic signed [47:0] total_weight
);

	logic               rsp_acc;
	logic signed [47:0] last_total_q;

	assign rsp_acc = rsp_valid && !rsp_stall;

	// Total of the last delivered item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_total_q <= '0;
		end else if (rsp_acc) begin
			last_total_q <= total_weight;
		end
	end

	// A stalled item stays put
	`UFES_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
		rsp_valid && $stable(edge_taken) && $stable(closed_cycle) && $stable(total_weight),
		"stalled result changed")

	// The cycle edge is always a taken edge
	`UFES_ASSERT_NOW(a_closed_taken, rsp_valid && closed_cycle, edge_taken,
		"closed_cycle without edge_taken")

	// A refused edge keeps the total; a clear zeroes it
	`UFES_ASSERT_NOW(a_refused_total, rsp_valid && !edge_taken,
		(total_weight == last_total_q) || (total_weight == 48'sd0),
		"total moved on a refused item")

	// The forest init pass holds off items right after reset
	`UFES_ASSERT_NOW(a_init_stall, !$past(arst_n), req_stall,
		"item channel open during init pass")

endmodule

bind union_find_edge_selector ufes_chk u_chk (.*);

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;
	import ufes_pkg::*;

	localparam int IDLE_LIMIT = 20000;
	localparam int RANDOM_ITEMS = 1700;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	logic req_valid;
	logic req_stall;
	logic func;
	logic [NODE_W-1:0] src_node;
	logic [NODE_W-1:0] dst_node;
	logic signed [WEIGHT_W-1:0] edge_weight;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	logic edge_taken;
	logic closed_cycle;
	logic signed [SUM_W-1:0] total_weight;

	// shadow of the block state
	logic [NODE_W-1:0] forest_parent [0:1023];
	logic [RANK_W-1:0] forest_rank [0:1023];
	logic cycle_mark;
	logic signed [SUM_W-1:0] weight_total;
	logic [COUNT_W-1:0] node_limit;

	res_t pending_outcomes[$];
	int errors = 0;
	int idle_cycles = 0;
	int burst_left = 0;

	union_find_edge_selector #(.MAX_NODES(1024)) u_top (.*);

	always #2 clk = ~clk;

	function automatic void clear_forest();
		for (int i = 0; i < 1024; i++) begin
			forest_parent[i] = NODE_W'(i);
			forest_rank[i] = 4'd1;
		end
		cycle_mark = 1'b0;
		weight_total = '0;
	endfunction

	// root walk, then point every node on the path straight at the root
	function automatic logic [NODE_W-1:0] root_with_compress(logic [NODE_W-1:0] n);
		logic [NODE_W-1:0] r;
		logic [NODE_W-1:0] nxt;
		int guard;
		r = n;
		guard = 0;
		while (forest_parent[r] != r && guard < 1024) begin
			r = forest_parent[r];
			guard++;
		end
		while (n != r) begin
			nxt = forest_parent[n];
			forest_parent[n] = r;
			n = nxt;
		end
		return r;
	endfunction

	function automatic logic [RANK_W-1:0] merged_rank(logic [RANK_W-1:0] lower,
		logic [RANK_W-1:0] upper);
		logic [RANK_W:0] m;
		m = {1'b0, lower} + 5'd1;
		if (m < {1'b0, upper})
			m = {1'b0, upper};
		return (m > 5'd15) ? 4'd15 : m[RANK_W-1:0];
	endfunction

	// outcome of one item, advancing the shadow forest
	function automatic res_t kruskal_outcome(logic f, logic [NODE_W-1:0] a,
		logic [NODE_W-1:0] b, logic signed [WEIGHT_W-1:0] w);
		res_t o;
		logic [NODE_W-1:0] ra;
		logic [NODE_W-1:0] rb;
		logic taken;
		logic closed;
		longint s;
		taken = 1'b0;
		closed = 1'b0;
		if (f == FUNC_CLEAR) begin
			clear_forest();
		end else if ({1'b0, a} < node_limit && {1'b0, b} < node_limit) begin
			ra = root_with_compress(a);
			rb = root_with_compress(b);
			if (ra == rb) begin
				if (!cycle_mark) begin
					cycle_mark = 1'b1;
					taken = 1'b1;
					closed = 1'b1;
				end
			end else begin
				if (forest_rank[ra] < forest_rank[rb]) begin
					forest_parent[ra] = rb;
					forest_rank[rb] = merged_rank(forest_rank[ra], forest_rank[rb]);
				end else begin
					forest_parent[rb] = ra;
					forest_rank[ra] = merged_rank(forest_rank[rb], forest_rank[ra]);
				end
				taken = 1'b1;
			end
			if (taken) begin
				s = longint'(weight_total) + longint'(w);
				if (s > longint'(SUM_MAX))
					s = longint'(SUM_MAX);
				if (s < longint'(SUM_MIN))
					s = longint'(SUM_MIN);
				weight_total = s[SUM_W-1:0];
			end
		end
		o.edge_taken = taken;
		o.closed_cycle = closed;
		o.total_weight = weight_total;
		return o;
	endfunction

	task automatic note_failure(input string what);
		if (errors < 10)
			$display("%s", what);
		errors++;
	endtask

	// result check and item prediction, both on accepted handshakes
	always @(posedge clk) begin
		res_t want;
		if (arst_n) begin
			if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (rsp_valid && !rsp_stall) begin
				if (pending_outcomes.size() == 0) begin
					note_failure($sformatf("unexpected result: taken=%0b cycle=%0b total=%0d",
						edge_taken, closed_cycle, total_weight));
				end else begin
					want = pending_outcomes.pop_front();
					if (want.edge_taken !== edge_taken || want.closed_cycle !== closed_cycle ||
						want.total_weight !== total_weight) begin
						note_failure($sformatf({"mismatch: expected taken=%0b cycle=%0b ",
							"total=%0d, got taken=%0b cycle=%0b total=%0d"},
							want.edge_taken, want.closed_cycle, want.total_weight,
							edge_taken, closed_cycle, total_weight));
					end
				end
			end
			if (req_valid && !req_stall)
				pending_outcomes.push_back(kruskal_outcome(func, src_node, dst_node,
					edge_weight));
		end
	end

	// receiver stall pattern, switching between four modes at random
	int stall_mode = 0;
	int mode_left = 0;
	always @(negedge clk) begin
		if (mode_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			mode_left = $urandom_range(50, 400);
		end else begin
			mode_left--;
		end
		case (stall_mode)
			0: rsp_stall <= 1'b0;
			1: rsp_stall <= ($urandom_range(0, 3) == 0);
			2: rsp_stall <= ($urandom_range(0, 3) != 0);
			default: rsp_stall <= ~rsp_stall;
		endcase
	end

	// watchdog: too long without any handshake
	initial begin
		while (idle_cycles < IDLE_LIMIT)
			@(posedge clk);
		$display("FAILED: results differ");
		$finish;
	end

	// send one item, in bursts with random gaps between them
	task automatic send_item(input logic f, input int a, input int b, input longint w);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				@(negedge clk) req_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		func <= f;
		src_node <= NODE_W'(a);
		dst_node <= NODE_W'(b);
		edge_weight <= WEIGHT_W'(w);
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
	endtask

	// stop sending and wait until every result is back
	task automatic settle_block();
		@(negedge clk) req_valid <= 1'b0;
		burst_left = 0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic cfg_access(input logic wr, input logic [31:0] wdata,
		output logic [31:0] rdata);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {REG_NODE_COUNT, 2'b00};
		pwdata <= wdata;
		@(negedge clk) penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic check_node_count();
		logic [31:0] rd;
		cfg_access(1'b0, 32'd0, rd);
		if (rd[COUNT_W-1:0] !== node_limit)
			note_failure($sformatf("node_count read %0d, expected %0d",
				rd[COUNT_W-1:0], node_limit));
	endtask

	task automatic set_node_count(input int value);
		logic [31:0] rd;
		cfg_access(1'b1, 32'(value), rd);
		node_limit = COUNT_W'(value);
		check_node_count();
	endtask

	task automatic test_register_defaults();
		check_node_count();
	endtask

	// extremes, self loops, the single allowed cycle and a short chain
	task automatic test_directed_edges();
		send_item(FUNC_CLEAR, 1023, 1023, -1);
		send_item(FUNC_EDGE, 7, 7, 5);
		send_item(FUNC_EDGE, 3, 3, 6);
		send_item(FUNC_EDGE, 0, 1023, 2147483647);
		send_item(FUNC_EDGE, 1023, 0, 2147483647);
		send_item(FUNC_EDGE, 1, 2, -2147483648);
		send_item(FUNC_EDGE, 2, 1023, -2147483648);
		send_item(FUNC_EDGE, 512, 511, 0);
		send_item(FUNC_EDGE, 4, 5, 1);
		send_item(FUNC_EDGE, 6, 4, 1);
		send_item(FUNC_EDGE, 5, 511, 2);
		send_item(FUNC_EDGE, 6, 1, 3);
		send_item(FUNC_EDGE, 0, 6, 4);
		send_item(FUNC_CLEAR, 0, 0, 0);
	endtask

	// endpoints at and past the node count, down to a count of zero
	task automatic test_node_count_limits();
		settle_block();
		set_node_count(0);
		send_item(FUNC_EDGE, 0, 0, 9);
		send_item(FUNC_EDGE, 1, 2, 9);
		settle_block();
		set_node_count(1);
		send_item(FUNC_EDGE, 0, 0, 10);
		send_item(FUNC_EDGE, 0, 1, 11);
		send_item(FUNC_EDGE, 1, 0, 12);
		settle_block();
		set_node_count(2);
		send_item(FUNC_CLEAR, 5, 6, 7);
		send_item(FUNC_EDGE, 0, 1, -3);
		send_item(FUNC_EDGE, 1, 1, -2);
		send_item(FUNC_EDGE, 2, 0, 1);
		settle_block();
		set_node_count(1024);
	endtask

	// mostly well-formed graphs in ascending weight order, some noise
	task automatic test_random_graphs();
		int phase_counts[10] = '{1024, 40, 2, 1024, 300, 1, 1000, 64, 1024, 7};
		int sent;
		int phase;
		int phase_items;
		int n_used;
		int k;
		int r;
		int step_max;
		longint cur;
		sent = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			settle_block();
			set_node_count(phase_counts[phase % 10]);
			phase++;
			phase_items = 0;
			while (phase_items < 170) begin
				send_item(FUNC_CLEAR, $urandom_range(0, 1023), $urandom_range(0, 1023),
					$signed($urandom));
				phase_items++;
				if (node_limit <= 64)
					n_used = $urandom_range(1, node_limit);
				else if ($urandom_range(0, 9) < 7)
					n_used = $urandom_range(2, 48);
				else
					n_used = $urandom_range(49, node_limit);
				k = $urandom_range(1, n_used + n_used / 2 + 2);
				if (k > 220)
					k = 220;
				case ($urandom_range(0, 3))
					0: step_max = 2;
					1: step_max = 1000;
					2: step_max = 1 << 24;
					default: step_max = 1 << 28;
				endcase
				cur = longint'($signed($urandom));
				for (int i = 0; i < k; i++) begin
					r = $urandom_range(0, 99);
					cur += $urandom_range(0, step_max);
					if (cur > 64'sd2147483647)
						cur = 64'sd2147483647;
					if (r < 3)
						send_item(FUNC_CLEAR, $urandom_range(0, 1023),
							$urandom_range(0, 1023), $signed($urandom));
					else if (r < 8)
						send_item(FUNC_EDGE, $urandom_range(0, 1023),
							$urandom_range(0, 1023), $signed($urandom));
					else
						send_item(FUNC_EDGE, $urandom_range(0, n_used - 1),
							$urandom_range(0, n_used - 1), cur);
					phase_items++;
				end
			end
			sent += phase_items;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_valid = 1'b0;
		func = FUNC_CLEAR;
		src_node = '0;
		dst_node = '0;
		edge_weight = '0;
		clear_forest();
		node_limit = NODE_COUNT_RST;
		repeat (11) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		test_register_defaults();
		test_directed_edges();
		test_node_count_limits();
		test_random_graphs();

		settle_block();
		repeat (20) @(posedge clk);
		if (errors == 0 && pending_outcomes.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

[filelist.f]
+incdir+src
src/ufes_pkg.sv
src/ufes_ram.sv
src/ufes_ctrl.sv
src/union_find_edge_selector.sv
src/ufes_chk.sv
sim/testbench.sv
